FILE: hw/rtl/linear_concat_sector_mapper_unit_macros.svh
// Assertion macros used by the sector mapper back end (lcsm_back).
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef LINEAR_CONCAT_SECTOR_MAPPER_UNIT_MACROS_SVH
`define LINEAR_CONCAT_SECTOR_MAPPER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LCSM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcsm assertion failed");
// next-cycle implication
`define LCSM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcsm assertion failed");
`else
`define LCSM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LCSM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/lcsm_pkg.sv
// Types and constants for the linear concatenation sector mapper.
// No dependencies; imported by every RTL module of the block.
package lcsm_pkg;

    localparam int START_W   = 48;          // virtual/local sector number
    localparam int COUNT_W   = 23;          // request / piece length
    localparam int DEV_W     = 2;           // device index
    localparam int DEV_SLOTS = 4;           // size registers implemented
    localparam int END_W     = START_W + 1; // start + count
    localparam int TOP_W     = START_W + 2; // sum of four device sizes
    localparam int DCNT_W    = 3;           // dev_count register
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;
    localparam int M_PAD_W   = M_TDATA_W - DEV_W - START_W - COUNT_W;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV0_SECTORS = 3'd1;

    // configuration as seen by the datapath: running device end sectors
    typedef struct packed {
        logic [DEV_SLOTS-1:0][TOP_W-1:0] tops;   // end sector of device i
        logic [DEV_SLOTS-1:0]            nz;     // device i has nonzero size
        logic [DCNT_W-1:0]               n_act;  // active devices, 1..4
    } lcsm_cfg_t;

    // classified request, front to back
    typedef struct packed {
        logic [START_W-1:0]   start;
        logic [END_W-1:0]     last_sec;   // start + count
        logic                 err;
        logic                 zero;
        logic [DEV_W-1:0]     zdev;       // target of a zero-length request
        logic [DEV_SLOTS-1:0] mask;       // devices the range touches
    } lcsm_entry_t;

endpackage

FILE: hw/rtl/lcsm_cfg.sv
// Configuration registers and running device end sectors.
// Depends on lcsm_pkg.
module lcsm_cfg import lcsm_pkg::*; #(
    parameter int NUM_DEV = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output lcsm_cfg_t            cfg,
    output logic                 settled
);

    localparam int SET_W = $clog2(NUM_DEV + 1);

    logic [DCNT_W-1:0]                dev_count_reg;
    logic [NUM_DEV-1:0][START_W-1:0]  size_reg;
    logic [NUM_DEV-1:0][TOP_W-1:0]    tops_reg;
    logic [SET_W-1:0]                 settle_reg;
    logic [DCNT_W-1:0]                n_act;

    // tops ripple one device per cycle; settle_reg covers the ripple
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_count_reg <= DCNT_W'(1);
            size_reg      <= '0;
            tops_reg      <= '0;
            settle_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_DEV_COUNT) begin
                    dev_count_reg <= cfg_data[DCNT_W-1:0];
                end
                for (int i = 0; i < NUM_DEV; i++) begin
                    if (cfg_index == CFG_IDX_W'(int'(REG_DEV0_SECTORS) + i)) begin
                        size_reg[i] <= cfg_data[START_W-1:0];
                    end
                end
                settle_reg <= SET_W'(NUM_DEV);
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - SET_W'(1);
            end
            tops_reg[0] <= {2'b00, size_reg[0]};
            for (int i = 1; i < NUM_DEV; i++) begin
                tops_reg[i] <= tops_reg[i-1] + {2'b00, size_reg[i]};
            end
        end
    end

    always_comb begin
        if (dev_count_reg == '0) begin
            n_act = DCNT_W'(1);
        end else if (dev_count_reg > DCNT_W'(NUM_DEV)) begin
            n_act = DCNT_W'(NUM_DEV);
        end else begin
            n_act = dev_count_reg;
        end
    end

    always_comb begin
        cfg.n_act = n_act;
        for (int i = 0; i < DEV_SLOTS; i++) begin
            if (i < NUM_DEV) begin
                cfg.tops[i] = tops_reg[i];
                cfg.nz[i]   = (size_reg[i] != '0);
            end else begin
                cfg.tops[i] = '1;
                cfg.nz[i]   = 1'b0;
            end
        end
    end

    assign settled = (settle_reg == '0);

endmodule

FILE: hw/rtl/lcsm_front.sv
// Front end: range check and device classification of one request.
// Depends on lcsm_pkg.
module lcsm_front import lcsm_pkg::*; (
    input  logic [START_W-1:0] start_sector,
    input  logic [COUNT_W-1:0] sector_count,
    input  lcsm_cfg_t          cfg,
    output lcsm_entry_t        entry
);

    logic [END_W-1:0]     last_sec;
    logic [TOP_W-1:0]     total;
    logic [DEV_SLOTS-1:0] below_top;
    logic [DEV_SLOTS-1:0] above_base;
    logic [DEV_SLOTS-1:0] active;
    logic [DEV_W-1:0]     zdev;
    logic                 found;

    assign last_sec = {1'b0, start_sector} + {{(END_W-COUNT_W){1'b0}}, sector_count};
    assign total    = cfg.tops[DEV_W'(cfg.n_act - DCNT_W'(1))];

    always_comb begin
        for (int i = 0; i < DEV_SLOTS; i++) begin
            active[i]    = (DCNT_W'(i) < cfg.n_act);
            below_top[i] = ({2'b00, start_sector} < cfg.tops[i]);
            if (i == 0) begin
                above_base[i] = (last_sec != '0);
            end else begin
                above_base[i] = ({1'b0, last_sec} > cfg.tops[(i == 0) ? 0 : i - 1]);
            end
        end
    end

    // zero-length: first active device holding the start, else the last one
    always_comb begin
        zdev  = DEV_W'(cfg.n_act - DCNT_W'(1));
        found = 1'b0;
        for (int i = 0; i < DEV_SLOTS; i++) begin
            if (!found && active[i] && below_top[i]) begin
                zdev  = DEV_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        entry.start    = start_sector;
        entry.last_sec = last_sec;
        entry.err      = ({1'b0, last_sec} > total);
        entry.zero     = (sector_count == '0);
        entry.zdev     = zdev;
        entry.mask     = active & cfg.nz & below_top & above_base;
    end

endmodule

FILE: hw/rtl/lcsm_queue.sv
// Short queue of classified requests between front and back end.
// Depends on lcsm_pkg.
module lcsm_queue import lcsm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  lcsm_entry_t push_entry,
    input  logic        pop,
    output lcsm_entry_t head,
    output logic        head_valid,
    output logic        full
);

    lcsm_entry_t        slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));

endmodule

FILE: hw/rtl/lcsm_back.sv
// Back end: splits a classified request into per-device pieces and
// drives the output register. Depends on lcsm_pkg and the macro header.
`include "linear_concat_sector_mapper_unit_macros.svh"
module lcsm_back import lcsm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcsm_cfg_t            cfg,
    input  lcsm_entry_t          head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // device_index, local_sector, piece_sectors
    output logic [0:0]           m_tuser,   // out_of_range
    output logic                 m_tlast    // last_piece
);

    logic                            started_reg;
    logic [DEV_SLOTS-1:0]            rem_reg;
    logic                            m_tvalid_reg;
    logic [M_TDATA_W-1:0]            m_tdata_reg;
    logic                            m_tuser_reg;
    logic                            m_tlast_reg;

    logic [DEV_SLOTS-1:0][TOP_W-1:0] bases;
    logic [DEV_SLOTS-1:0]            rem;
    logic [DEV_SLOTS-1:0]            rem_left;
    logic [DEV_W-1:0]                cur;
    logic [DEV_W-1:0]                bsel;
    logic                            hit;
    logic                            first;
    logic                            last_pc;
    logic                            single;
    logic                            can_load;
    logic                            fire;
    logic [TOP_W-1:0]                local_full;
    logic [TOP_W-1:0]                lo;
    logic [TOP_W-1:0]                hi;
    logic [TOP_W-1:0]                len_full;
    logic [DEV_W-1:0]                dev_next;
    logic [START_W-1:0]              local_next;
    logic [COUNT_W-1:0]              len_next;
    logic                            last_next;

    always_comb begin
        for (int i = 0; i < DEV_SLOTS; i++) begin
            bases[i] = (i == 0) ? '0 : cfg.tops[(i == 0) ? 0 : i - 1];
        end
    end

    assign rem = started_reg ? rem_reg : head.mask;

    always_comb begin
        cur = '0;
        hit = 1'b0;
        for (int i = 0; i < DEV_SLOTS; i++) begin
            if (!hit && rem[i]) begin
                cur = DEV_W'(i);
                hit = 1'b1;
            end
        end
    end

    assign rem_left = rem & ~(DEV_SLOTS'(1) << cur);
    assign first    = !started_reg;
    assign last_pc  = (rem_left == '0);
    assign single   = head.err | head.zero;
    assign bsel     = head.zero ? head.zdev : cur;

    // only the first piece starts inside a device; later ones start at its base
    assign local_full = {2'b00, head.start} - bases[bsel];
    assign lo         = first ? {2'b00, head.start} : bases[cur];
    assign hi         = last_pc ? {1'b0, head.last_sec} : cfg.tops[cur];
    assign len_full   = hi - lo;

    assign can_load = !m_tvalid_reg || m_tready;
    assign fire     = head_valid && can_load;
    assign pop      = fire && (single || last_pc);

    always_comb begin
        if (head.err) begin
            dev_next   = '0;
            local_next = '0;
            len_next   = '0;
            last_next  = 1'b1;
        end else if (head.zero) begin
            dev_next   = head.zdev;
            local_next = local_full[START_W-1:0];
            len_next   = '0;
            last_next  = 1'b1;
        end else begin
            dev_next   = cur;
            local_next = first ? local_full[START_W-1:0] : '0;
            len_next   = len_full[COUNT_W-1:0];
            last_next  = last_pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_tvalid_reg <= 1'b1;
                if (pop) begin
                    started_reg <= 1'b0;
                end else begin
                    started_reg <= 1'b1;
                    rem_reg     <= rem_left;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, len_next, local_next, dev_next};
            m_tuser_reg <= head.err;
            m_tlast_reg <= last_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // a rejected request is one result with empty fields
    `LCSM_ASSERT_IMP(a_err_single, aclk, aresetn,
        m_tvalid_reg && m_tuser_reg, m_tlast_reg && (m_tdata_reg == '0))
    // an accepted nonempty request always has a device left to serve
    `LCSM_ASSERT_IMP(a_piece_has_dev, aclk, aresetn,
        fire && !single, rem != '0)
    // the split state clears once the request leaves the queue
    `LCSM_ASSERT_NXT(a_pop_clears, aclk, aresetn, pop, !started_reg)
    // a continuing split only happens with an entry at the head
    `LCSM_ASSERT_IMP(a_started_head, aclk, aresetn, started_reg, head_valid)

endmodule

FILE: hw/rtl/linear_concat_sector_mapper_unit.sv
// An accepted request passes the queue slot register, then the output register.
// Throughput: one request per cycle when it maps to a single device or is rejected
// and the output is not stalled; a request spanning several devices holds the back
// end until its last piece is taken. After a configuration write, input is held off
// while the device end sectors ripple through. Reset (aresetn low, synchronous) sets
// dev_count to 1, all sizes to 0 and empties the queue and output register.
module linear_concat_sector_mapper_unit import lcsm_pkg::*; #(
    parameter int MAX_DEVICES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // start_sector, sector_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // device_index, local_sector, piece_sectors
    output logic [0:0]           m_tuser,   // out_of_range
    output logic                 m_tlast,   // last_piece
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int NUM_DEV = (MAX_DEVICES < DEV_SLOTS) ? MAX_DEVICES : DEV_SLOTS;

    lcsm_cfg_t   cfg;
    logic        settled;
    lcsm_entry_t entry;
    lcsm_entry_t head;
    logic        head_valid;
    logic        q_full;
    logic        pop;
    logic        push;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && settled;
    assign push      = s_tvalid && s_tready;

    lcsm_cfg #(
        .NUM_DEV (NUM_DEV)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .settled   (settled)
    );

    lcsm_front u_front (
        .start_sector (s_tdata[START_W-1:0]),
        .sector_count (s_tdata[START_W+COUNT_W-1:START_W]),
        .cfg          (cfg),
        .entry        (entry)
    );

    lcsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    lcsm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: tb/tb_linear_concat_sector_mapper_unit.sv
// Self-checking testbench for linear_concat_sector_mapper_unit: predicts the pieces of each
// request from its own copy of the device sizes and checks them in order.
// Depends on lcsm_pkg and the mapper RTL only.
`timescale 1ns / 100ps

module tb_linear_concat_sector_mapper_unit;
    import lcsm_pkg::*;

    localparam int MAX_DEVICES = 4;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [START_W-1:0]   SECTOR_MAX = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX  = '1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_DEV0_SECTORS + DEV_SLOTS;

    typedef struct {
        logic [DEV_W-1:0]   dev;
        logic [START_W-1:0] lsec;
        logic [COUNT_W-1:0] len;
        logic               err;
        logic               is_last;
    } piece_t;

    // Device map copy plus the queue of pieces still owed by the block.
    class concat_map_tracker;
        logic [DCNT_W-1:0]  dev_count;
        logic [START_W-1:0] dev_sectors[DEV_SLOTS];
        piece_t             expected_pieces[$];
        int unsigned        mismatches;

        function new();
            dev_count = 1;
            foreach (dev_sectors[i]) dev_sectors[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_DEV_COUNT) begin
                dev_count = data[DCNT_W-1:0];
            end else if (idx >= REG_DEV0_SECTORS && idx < REG_FIRST_UNUSED) begin
                dev_sectors[idx - REG_DEV0_SECTORS] = data[START_W-1:0];
            end
        endfunction

        function int active_count();
            int n;
            n = dev_count;
            if (n == 0) n = 1;
            if (n > MAX_DEVICES) n = MAX_DEVICES;
            if (n > DEV_SLOTS) n = DEV_SLOTS;
            return n;
        endfunction

        // first sector of device upto, i.e. sum of the sizes below it
        function logic [63:0] boundary(int upto);
            logic [63:0] sum;
            sum = 0;
            for (int i = 0; i < upto; i++) sum += dev_sectors[i];
            return sum;
        endfunction

        function logic [63:0] capacity();
            return boundary(active_count());
        endfunction

        function void push_piece(int dev, logic [63:0] lsec, logic [63:0] len, bit err,
                                 bit is_last);
            piece_t p;
            p.dev     = DEV_W'(dev);
            p.lsec    = lsec[START_W-1:0];
            p.len     = len[COUNT_W-1:0];
            p.err     = err;
            p.is_last = is_last;
            expected_pieces.push_back(p);
        endfunction

        function void note_request(logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
            logic [63:0] st, cnt, s_end, base, top, lo, hi;
            int n;
            bit placed;
            st = start;
            cnt = count;
            s_end = st + cnt;
            n = active_count();
            base = 0;
            placed = 0;
            if (s_end > capacity()) begin
                push_piece(0, 0, 0, 1, 1);
            end else if (cnt == 0) begin
                for (int i = 0; i < n && !placed; i++) begin
                    top = base + dev_sectors[i];
                    if (st < top) begin
                        push_piece(i, st - base, 0, 0, 1);
                        placed = 1;
                    end else if (i + 1 < n) begin
                        base = top;
                    end
                end
                // start sits exactly at the capacity end
                if (!placed) push_piece(n - 1, st - base, 0, 0, 1);
            end else begin
                for (int i = 0; i < n && !placed; i++) begin
                    top = base + dev_sectors[i];
                    lo = (st > base) ? st : base;
                    hi = (s_end < top) ? s_end : top;
                    if (lo < hi) begin
                        push_piece(i, lo - base, hi - lo, 0, hi == s_end);
                        placed = (hi == s_end);
                    end
                    base = top;
                end
            end
        endfunction

        task report(string what);
            if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_piece(logic [M_TDATA_W-1:0] data, logic oor, logic tail);
            piece_t want;
            logic [DEV_W-1:0]   dev;
            logic [START_W-1:0] lsec;
            logic [COUNT_W-1:0] len;
            dev  = data[DEV_W-1:0];
            lsec = data[DEV_W +: START_W];
            len  = data[DEV_W+START_W +: COUNT_W];
            if (expected_pieces.size() == 0) begin
                report($sformatf("unexpected item dev %0d lsec %0h len %0h", dev, lsec, len));
            end else begin
                want = expected_pieces.pop_front();
                if (dev !== want.dev)
                    report($sformatf("device_index got %0d want %0d", dev, want.dev));
                if (lsec !== want.lsec)
                    report($sformatf("local_sector got %0h want %0h", lsec, want.lsec));
                if (len !== want.len)
                    report($sformatf("piece_sectors got %0h want %0h", len, want.len));
                if (oor !== want.err)
                    report($sformatf("out_of_range got %b want %b", oor, want.err));
                if (tail !== want.is_last)
                    report($sformatf("last_piece got %b want %b", tail, want.is_last));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    concat_map_tracker map_check;
    int s_gap_pct   = 18;
    int m_stall_pct = 60;
    int quiet_cycles = 0;

    linear_concat_sector_mapper_unit #(
        .MAX_DEVICES(MAX_DEVICES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: check at the accepting edge, then pick next cycle's stall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) map_check.check_piece(m_tdata, m_tuser[0], m_tlast);
        m_tready <= ($urandom_range(99) >= m_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [START_W-1:0] rnd48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[START_W-1:0];
    endfunction

    function automatic logic [63:0] rand_upto(logic [63:0] n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r % (n + 1);
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_size();
        int k;
        k = $urandom_range(99);
        if (k < 10) return '0;
        if (k < 55) return CFG_DAT_W'($urandom_range(1, 4000));
        if (k < 85) return CFG_DAT_W'($urandom_range(1, 24'hFF_FFFF));
        return rnd48();
    endfunction

    task automatic wait_drained();
        while (map_check.expected_pieces.size() != 0) @(posedge aclk);
    endtask

    // valid is left high on acceptance so back-to-back items need no toggle
    task automatic send_request(logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < s_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-START_W-COUNT_W){1'b0}}, count, start};
        do @(posedge aclk); while (!s_tready);
        map_check.note_request(start, count);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        map_check.write_reg(idx, data);
    endtask

    // quiets the request side and waits until all pieces are returned before writing
    task automatic apply_setup(logic [CFG_DAT_W-1:0] dcount, logic [CFG_DAT_W-1:0] sz0,
                               logic [CFG_DAT_W-1:0] sz1, logic [CFG_DAT_W-1:0] sz2,
                               logic [CFG_DAT_W-1:0] sz3, bit poke_unused);
        s_tvalid <= 1'b0;
        wait_drained();
        write_reg(REG_DEV_COUNT, dcount);
        write_reg(REG_DEV0_SECTORS, sz0);
        write_reg(REG_DEV0_SECTORS + 1, sz1);
        write_reg(REG_DEV0_SECTORS + 2, sz2);
        write_reg(REG_DEV0_SECTORS + 3, sz3);
        if (poke_unused)
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)), rnd48());
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [63:0] total, start, room, cnt, b, off;
        int kind;
        total = map_check.capacity();
        kind = $urandom_range(99);
        if (kind < 25) begin
            send_request(rnd48(), COUNT_W'($urandom));
        end else begin
            // well formed; three in five of them start close to a device boundary
            if (kind < 55) begin
                start = rand_upto(total);
            end else begin
                b = map_check.boundary($urandom_range(map_check.active_count()));
                off = $urandom_range(3000);
                start = (b > off) ? b - off : 0;
            end
            if (start > SECTOR_MAX) start = SECTOR_MAX;
            room = total - start;
            if (room > COUNT_MAX) room = COUNT_MAX;
            kind = $urandom_range(99);
            if (kind < 10) cnt = 0;
            else if (kind < 20) cnt = room;
            else if (kind < 60) cnt = rand_upto(room);
            else cnt = rand_upto((room < 5000) ? room : 5000);
            send_request(start[START_W-1:0], cnt[COUNT_W-1:0]);
        end
    endtask

    initial begin
        map_check = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // four devices, the second one empty
        apply_setup(4, 100, 0, 50, 200, 0);
        send_request(0, 0);
        send_request(100, 0);       // zero length skips the empty device
        send_request(350, 0);       // zero length at the capacity end
        send_request(300, 50);      // ends exactly at capacity
        send_request(0, 350);
        send_request(120, 100);
        send_request(300, 51);
        send_request(351, 0);
        send_request(10, 20);

        // count 0 behaves as one device; largest device size
        apply_setup(0, SECTOR_MAX, 5, 7, 9, 1);
        send_request(SECTOR_MAX, 0);
        send_request(SECTOR_MAX - COUNT_MAX, COUNT_MAX);
        send_request(SECTOR_MAX, 1);
        send_request(0, COUNT_MAX);

        // count above the device limit saturates
        apply_setup(7, SECTOR_MAX, SECTOR_MAX, SECTOR_MAX, SECTOR_MAX, 1);
        send_request(SECTOR_MAX - 5, COUNT_MAX);
        send_request(0, 0);
        send_request(SECTOR_MAX, 0);

        apply_setup(2, 1, 1, 0, 0, 0);
        send_request(0, 2);
        send_request(2, 0);
        send_request(1, 2);

        for (int phase = 0; phase < 3; phase++) begin
            s_gap_pct   = (phase == 0) ? 18 : (phase == 1) ? 60 : 0;
            m_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 18 : 0;
            repeat (3) begin
                apply_setup($urandom_range(7), pick_size(), pick_size(), pick_size(),
                            pick_size(), $urandom_range(1));
                repeat (24) random_request();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);
        if (map_check.mismatches == 0 && map_check.expected_pieces.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
